@@ hdl/assert_macros.svh @@
// assertion helpers used by the compactor rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define DTEC_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// same-cycle implication
`define DTEC_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DTEC_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/dtec_pkg.sv @@
// ----------------------------------------------------------------------------
// dtec_pkg
// Types and codes shared by the decal triangle expiry compactor.
// ----------------------------------------------------------------------------
`default_nettype none

package dtec_pkg;

    localparam int VERT_W = 6;
    localparam int TIME_W = 31;

    localparam logic FUNC_APPEND = 1'b0;
    localparam logic FUNC_SWEEP  = 1'b1;

    localparam logic REG_STAY_TIME = 1'b0;

    typedef enum logic [1:0] {
        KIND_ACK     = 2'd0,
        KIND_TRI     = 2'd1,
        KIND_MOVE    = 2'd2,
        KIND_SUMMARY = 2'd3
    } dtec_kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COMPACT,
        ST_EMPTY,
        ST_REMAP,
        ST_TRI_RD,
        ST_TRI_CAP,
        ST_TRI_RM,
        ST_TRI_OUT,
        ST_MOVE,
        ST_SUMMARY
    } dtec_state_t;

    // table entry, first vertex in the lowest bits
    typedef struct packed {
        logic [TIME_W-1:0] t;
        logic [VERT_W-1:0] c;
        logic [VERT_W-1:0] b;
        logic [VERT_W-1:0] a;
    } dtec_tri_t;

    localparam int TRI_W = $bits(dtec_tri_t);

    typedef struct packed {
        dtec_kind_t        kind;
        logic [VERT_W-1:0] idx_a;
        logic [VERT_W-1:0] idx_b;
        logic [VERT_W-1:0] idx_c;
        logic [TIME_W-1:0] tri_time;
        logic              changed;
        logic              emptied;
        logic              rejected;
        logic              last;
    } dtec_out_t;

endpackage

`default_nettype wire

@@ hdl/dtec_ram.sv @@
// ----------------------------------------------------------------------------
// dtec_ram
// Generic simple dual-port ram, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dtec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  aclk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ hdl/decal_triangle_expiry_compactor.sv @@
// ----------------------------------------------------------------------------
// decal_triangle_expiry_compactor
// Triangle table of one decal mesh with append, expiry sweep and vertex
// compaction.
// ----------------------------------------------------------------------------
// usage
//   input words on s_*: tuser selects append (0) or sweep (1); an append
//   stores one triangle and answers with one ack word. a sweep drops expired
//   triangles, packs the used vertices and answers with the kept triangles,
//   one move word per kept vertex and a summary word with tlast set. every
//   input word ends with a result word carrying tlast. the user writes
//   stay_time over the apb port only while the block is idle; not enforced.
// timing
//   an append is accepted and its ack is on m_* the next cycle.
//   a sweep reads the table ram one entry per cycle, then walks the vertex
//   map one vertex per cycle, then takes each kept triangle through the
//   states ST_TRI_RD, ST_TRI_CAP, ST_TRI_RM and ST_TRI_OUT for the table
//   and remap ram reads, then walks the vertex map again for the move
//   words and ends with the summary word, going straight to the summary
//   when nothing is kept. the next input word is taken no earlier than the
//   cycle in which the summary word leaves.
// reset and stall
//   reset empties the table and clears the vertex map; ram contents are not
//   cleared. a stalled m_tready holds the output word and pauses the output
//   walk.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module decal_triangle_expiry_compactor #(
    parameter int MAX_VERTS = 40,
    parameter int MAX_TRIS  = 20
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    // vert_a, vert_b, vert_c, start_time, now_time, vert_count, zero pad
    input  wire logic [87:0] s_tdata,
    // func
    input  wire logic [0:0]  s_tuser,

    output logic             m_tvalid,
    input  wire logic        m_tready,
    // idx_a, idx_b, idx_c, tri_time, changed, emptied, rejected, zero pad
    output logic      [55:0] m_tdata,
    // kind
    output logic      [1:0]  m_tuser,
    output logic             m_tlast,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    import dtec_pkg::*;

    localparam int TCW = $clog2(MAX_TRIS + 1);
    localparam int TIW = (MAX_TRIS > 1) ? $clog2(MAX_TRIS) : 1;
    localparam int VCW = $clog2(MAX_VERTS + 1);
    localparam int VIW = $clog2(MAX_VERTS);

    function automatic logic in_mesh(input logic [VERT_W-1:0] x,
                                     input logic [VCW-1:0] vc);
        return 7'(x) < 7'(vc);
    endfunction

    dtec_state_t          state_reg, state_next;
    logic [TCW-1:0]       tri_count_reg, tri_count_next;
    logic [TCW-1:0]       idx_reg, idx_next;
    logic [TCW-1:0]       kept_reg, kept_next;
    logic                 pend_reg, pend_next;
    logic [VCW-1:0]       v_reg, v_next;
    logic [VCW-1:0]       newv_reg, newv_next;
    logic [VCW-1:0]       mv_reg, mv_next;
    logic [VCW-1:0]       vc_reg, vc_next;
    logic [TIME_W-1:0]    now_reg, now_next;
    logic [TIME_W-1:0]    stay_reg;
    logic [MAX_VERTS-1:0] used_reg, used_next;
    dtec_tri_t            ent_reg, ent_next;
    dtec_out_t            out_reg, out_next;
    logic                 m_tvalid_reg;

    logic                 out_free;
    logic                 out_load;
    logic                 s_acc;
    logic                 sweep_acc;
    logic                 keep;

    logic                 tri_we;
    logic [TIW-1:0]       tri_waddr;
    dtec_tri_t            tri_wdata;
    dtec_tri_t            tri_rdata;
    logic [TRI_W-1:0]     tri_rdata_raw;

    logic                 rm_we;
    logic [VERT_W-1:0]    rm_rdata [3];
    logic [VERT_W-1:0]    ev [3];
    logic [VERT_W-1:0]    nv [3];
    logic [VERT_W-1:0]    cv [3];

    logic [VERT_W-1:0]    in_a, in_b, in_c, in_cnt;
    logic [TIME_W-1:0]    in_start, in_now;

    assign in_a     = s_tdata[5:0];
    assign in_b     = s_tdata[11:6];
    assign in_c     = s_tdata[17:12];
    assign in_start = s_tdata[48:18];
    assign in_now   = s_tdata[79:49];
    assign in_cnt   = s_tdata[85:80];

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign s_acc    = s_tvalid && s_tready;
    assign sweep_acc = s_acc && (s_tuser[0] == FUNC_SWEEP);

    assign tri_rdata = dtec_tri_t'(tri_rdata_raw);

    assign cv[0] = tri_rdata.a;
    assign cv[1] = tri_rdata.b;
    assign cv[2] = tri_rdata.c;
    assign ev[0] = ent_reg.a;
    assign ev[1] = ent_reg.b;
    assign ev[2] = ent_reg.c;

    assign keep = ({1'b0, tri_rdata.t} + {1'b0, stay_reg}) > {1'b0, now_reg};

    // every in-mesh vertex of a kept triangle was marked during compaction
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            nv[j] = in_mesh(ev[j], vc_reg) ? rm_rdata[j] : ev[j];
        end
    end

    dtec_ram #(
        .WIDTH (TRI_W),
        .DEPTH (MAX_TRIS)
    ) u_tri_ram (
        .aclk  (aclk),
        .we    (tri_we),
        .waddr (tri_waddr),
        .wdata (tri_wdata),
        .raddr (idx_reg[TIW-1:0]),
        .rdata (tri_rdata_raw)
    );

    for (genvar g = 0; g < 3; g++) begin : g_remap
        dtec_ram #(
            .WIDTH (VERT_W),
            .DEPTH (MAX_VERTS)
        ) u_remap_ram (
            .aclk  (aclk),
            .we    (rm_we),
            .waddr (v_reg[VIW-1:0]),
            .wdata (VERT_W'(newv_reg)),
            .raddr (ev[g][VIW-1:0]),
            .rdata (rm_rdata[g])
        );
    end

    always_comb begin
        state_next     = state_reg;
        tri_count_next = tri_count_reg;
        idx_next       = idx_reg;
        kept_next      = kept_reg;
        pend_next      = pend_reg;
        v_next         = v_reg;
        newv_next      = newv_reg;
        mv_next        = mv_reg;
        vc_next        = vc_reg;
        now_next       = now_reg;
        used_next      = used_reg;
        ent_next       = ent_reg;
        out_next       = out_reg;
        out_load       = 1'b0;
        tri_we         = 1'b0;
        tri_waddr      = kept_reg[TIW-1:0];
        tri_wdata      = tri_rdata;
        rm_we          = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (s_tuser[0] == FUNC_APPEND) begin
                        out_load = 1'b1;
                        out_next = '{kind: KIND_ACK, idx_a: '0, idx_b: '0, idx_c: '0,
                                     tri_time: '0, changed: 1'b0, emptied: 1'b0,
                                     rejected: 1'b1, last: 1'b1};
                        if (tri_count_reg < TCW'(MAX_TRIS)) begin
                            tri_we            = 1'b1;
                            tri_waddr         = tri_count_reg[TIW-1:0];
                            tri_wdata         = '{t: in_start, c: in_c, b: in_b, a: in_a};
                            tri_count_next    = tri_count_reg + 1'b1;
                            out_next.rejected = 1'b0;
                        end
                    end else begin
                        now_next   = in_now;
                        vc_next    = (7'(in_cnt) > 7'(MAX_VERTS)) ?
                                     VCW'(MAX_VERTS) : VCW'(in_cnt);
                        idx_next   = '0;
                        kept_next  = '0;
                        pend_next  = 1'b0;
                        used_next  = '0;
                        state_next = ST_COMPACT;
                    end
                end
            end

            ST_COMPACT: begin
                pend_next = idx_reg < tri_count_reg;
                if (idx_reg < tri_count_reg) begin
                    idx_next = idx_reg + 1'b1;
                end
                if (pend_reg && keep) begin
                    tri_we    = 1'b1;
                    kept_next = kept_reg + 1'b1;
                    for (int j = 0; j < 3; j++) begin
                        if (in_mesh(cv[j], vc_reg)) begin
                            used_next[cv[j][VIW-1:0]] = 1'b1;
                        end
                    end
                end
                if (!(idx_reg < tri_count_reg) && !pend_reg) begin
                    v_next     = '0;
                    newv_next  = '0;
                    state_next = (kept_reg == '0) ? ST_EMPTY : ST_REMAP;
                end
            end

            ST_EMPTY: begin
                if (out_free) begin
                    out_load       = 1'b1;
                    out_next       = '{kind: KIND_SUMMARY, idx_a: '0, idx_b: '0,
                                       idx_c: '0, tri_time: '0,
                                       changed: (tri_count_reg != '0), emptied: 1'b1,
                                       rejected: 1'b0, last: 1'b1};
                    tri_count_next = '0;
                    used_next      = '0;
                    state_next     = ST_IDLE;
                end
            end

            ST_REMAP: begin
                if (v_reg == vc_reg) begin
                    idx_next   = '0;
                    state_next = ST_TRI_RD;
                end else begin
                    if (used_reg[v_reg[VIW-1:0]]) begin
                        rm_we     = 1'b1;
                        newv_next = newv_reg + 1'b1;
                    end
                    v_next = v_reg + 1'b1;
                end
            end

            ST_TRI_RD: begin
                state_next = ST_TRI_CAP;
            end

            ST_TRI_CAP: begin
                ent_next   = tri_rdata;
                state_next = ST_TRI_RM;
            end

            ST_TRI_RM: begin
                state_next = ST_TRI_OUT;
            end

            ST_TRI_OUT: begin
                if (out_free) begin
                    out_load  = 1'b1;
                    out_next  = '{kind: KIND_TRI, idx_a: nv[0], idx_b: nv[1], idx_c: nv[2],
                                  tri_time: ent_reg.t, changed: 1'b0, emptied: 1'b0,
                                  rejected: 1'b0, last: 1'b0};
                    tri_we    = 1'b1;
                    tri_waddr = idx_reg[TIW-1:0];
                    tri_wdata = '{t: ent_reg.t, c: nv[2], b: nv[1], a: nv[0]};
                    idx_next  = idx_reg + 1'b1;
                    if (TCW'(idx_reg + 1'b1) == kept_reg) begin
                        v_next     = '0;
                        mv_next    = '0;
                        state_next = ST_MOVE;
                    end else begin
                        state_next = ST_TRI_RD;
                    end
                end
            end

            ST_MOVE: begin
                if (v_reg == vc_reg) begin
                    state_next = ST_SUMMARY;
                end else if (used_reg[v_reg[VIW-1:0]]) begin
                    if (out_free) begin
                        out_load = 1'b1;
                        out_next = '{kind: KIND_MOVE, idx_a: VERT_W'(v_reg),
                                     idx_b: VERT_W'(mv_reg), idx_c: '0, tri_time: '0,
                                     changed: 1'b0, emptied: 1'b0, rejected: 1'b0,
                                     last: 1'b0};
                        mv_next  = mv_reg + 1'b1;
                        v_next   = v_reg + 1'b1;
                    end
                end else begin
                    v_next = v_reg + 1'b1;
                end
            end

            ST_SUMMARY: begin
                if (out_free) begin
                    out_load       = 1'b1;
                    out_next       = '{kind: KIND_SUMMARY, idx_a: VERT_W'(kept_reg),
                                       idx_b: VERT_W'(newv_reg), idx_c: '0,
                                       tri_time: '0,
                                       changed: (kept_reg != tri_count_reg) ||
                                                (newv_reg != vc_reg),
                                       emptied: 1'b0, rejected: 1'b0, last: 1'b1};
                    tri_count_next = kept_reg;
                    state_next     = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            tri_count_reg <= '0;
            idx_reg       <= '0;
            kept_reg      <= '0;
            pend_reg      <= 1'b0;
            v_reg         <= '0;
            newv_reg      <= '0;
            mv_reg        <= '0;
            used_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
            stay_reg      <= '0;
        end else begin
            state_reg     <= state_next;
            tri_count_reg <= tri_count_next;
            idx_reg       <= idx_next;
            kept_reg      <= kept_next;
            pend_reg      <= pend_next;
            v_reg         <= v_next;
            newv_reg      <= newv_next;
            mv_reg        <= mv_next;
            used_reg      <= used_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (psel && penable && pwrite && (paddr[2] == REG_STAY_TIME)) begin
                stay_reg <= pwdata[TIME_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        vc_reg  <= vc_next;
        now_reg <= now_next;
        ent_reg <= ent_next;
        out_reg <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {4'b0, out_reg.rejected, out_reg.emptied, out_reg.changed,
                       out_reg.tri_time, out_reg.idx_c, out_reg.idx_b, out_reg.idx_a};

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_STAY_TIME) ? {1'b0, stay_reg} : 32'd0;

    `DTEC_ASSERT(a_count_bound, aclk, aresetn, tri_count_reg <= TCW'(MAX_TRIS),
        "triangle count above table depth")
    `DTEC_ASSERT_IMP(a_compact_order, aclk, aresetn, state_reg == ST_COMPACT,
        kept_reg <= idx_reg, "compaction write ran ahead of the read")
    `DTEC_ASSERT_IMP(a_move_count, aclk, aresetn, state_reg == ST_MOVE,
        mv_reg <= newv_reg, "more moves than kept vertices")
    `DTEC_ASSERT_IMP(a_no_overwrite, aclk, aresetn, out_load, out_free,
        "output word overwritten before taken")
    `DTEC_ASSERT_NXT(a_sweep_clear, aclk, aresetn, sweep_acc, used_reg == '0,
        "vertex map not cleared at sweep start")

endmodule

`default_nettype wire

@@ tb/decal_triangle_expiry_compactor_tb.sv @@
// ----------------------------------------------------------------------------
// decal_triangle_expiry_compactor_tb
// Drives append and sweep words into the triangle table, predicts every ack,
// kept triangle, vertex move and summary, and checks them in order while
// both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module decal_triangle_expiry_compactor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dtec_pkg::*;

    localparam int          NVERT      = 40;
    localparam int          NTRI       = 20;
    localparam logic [30:0] TIME_MAX   = 31'h7FFF_FFFF;
    localparam int          IDLE_LIMIT = 4000;
    localparam logic [2:0]  STAY_ADDR  = 3'({REG_STAY_TIME, 2'b00});

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // table image kept by the predictor
    logic [5:0]  tbl_vert [NTRI][3];
    logic [30:0] tbl_time [NTRI];
    int          tbl_fill = 0;
    logic [30:0] stay_ms  = '0;

    dtec_out_t   awaited_words [$];
    int          fail_count    = 0;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int          hold_len      = 0;
    int          hold_seq      = 0;
    int          hold_seen     = 0;
    int          hold_left     = 0;
    int          idle_cycles   = 0;
    logic [30:0] clock_ms      = 31'd1000;

    decal_triangle_expiry_compactor DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic dtec_out_t result_word(dtec_kind_t kind, int a, int b, int c,
                                              logic [30:0] t, bit chg, bit emp,
                                              bit rej, bit lst);
        dtec_out_t w;
        w.kind     = kind;
        w.idx_a    = 6'(a);
        w.idx_b    = 6'(b);
        w.idx_c    = 6'(c);
        w.tri_time = t;
        w.changed  = chg;
        w.emptied  = emp;
        w.rejected = rej;
        w.last     = lst;
        return w;
    endfunction

    function automatic void predict_results(logic func, logic [5:0] va, logic [5:0] vb,
                                            logic [5:0] vc, logic [30:0] st,
                                            logic [30:0] nt, logic [5:0] vcount);
        int          eff;
        int          kept;
        int          old;
        int          newv;
        longint      expiry;
        bit          marked [NVERT];
        logic [5:0]  slot [NVERT];
        logic [5:0]  x;
        if (func == FUNC_APPEND) begin
            if (tbl_fill >= NTRI) begin
                awaited_words.push_back(result_word(KIND_ACK, 0, 0, 0, '0, 0, 0, 1, 1));
                return;
            end
            tbl_vert[tbl_fill][0] = va;
            tbl_vert[tbl_fill][1] = vb;
            tbl_vert[tbl_fill][2] = vc;
            tbl_time[tbl_fill]    = st;
            tbl_fill++;
            awaited_words.push_back(result_word(KIND_ACK, 0, 0, 0, '0, 0, 0, 0, 1));
            return;
        end
        eff    = (vcount > NVERT) ? NVERT : int'(vcount);
        expiry = longint'(nt) - longint'(stay_ms);
        old    = tbl_fill;
        kept   = 0;
        for (int i = 0; i < old; i++) begin
            if (longint'(tbl_time[i]) > expiry) begin
                tbl_vert[kept] = tbl_vert[i];
                tbl_time[kept] = tbl_time[i];
                kept++;
            end
        end
        tbl_fill = kept;
        if (kept == 0) begin
            awaited_words.push_back(result_word(KIND_SUMMARY, 0, 0, 0, '0,
                                                old != 0, 1, 0, 1));
            return;
        end
        for (int v = 0; v < NVERT; v++) begin
            marked[v] = 0;
        end
        for (int i = 0; i < kept; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (tbl_vert[i][j] < eff) begin
                    marked[tbl_vert[i][j]] = 1;
                end
            end
        end
        newv = 0;
        for (int v = 0; v < eff; v++) begin
            if (marked[v]) begin
                slot[v] = 6'(newv);
                newv++;
            end
        end
        for (int i = 0; i < kept; i++) begin
            for (int j = 0; j < 3; j++) begin
                x = tbl_vert[i][j];
                if (x < eff && marked[x]) begin
                    tbl_vert[i][j] = slot[x];
                end
            end
            awaited_words.push_back(result_word(KIND_TRI, tbl_vert[i][0], tbl_vert[i][1],
                                                tbl_vert[i][2], tbl_time[i], 0, 0, 0, 0));
        end
        for (int v = 0; v < eff; v++) begin
            if (marked[v]) begin
                awaited_words.push_back(result_word(KIND_MOVE, v, slot[v], 0, '0,
                                                    0, 0, 0, 0));
            end
        end
        awaited_words.push_back(result_word(KIND_SUMMARY, kept, newv, 0, '0,
                                            kept != old || newv != eff, 0, 0, 1));
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // result checker
    always @(posedge aclk) begin
        dtec_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_words.size() == 0) begin
                $error("unexpected word: kind %0d data %h", m_tuser, m_tdata);
                fail_count++;
            end else begin
                want = awaited_words.pop_front();
                check_field("kind",     want.kind,     m_tuser);
                check_field("idx_a",    want.idx_a,    m_tdata[5:0]);
                check_field("idx_b",    want.idx_b,    m_tdata[11:6]);
                check_field("idx_c",    want.idx_c,    m_tdata[17:12]);
                check_field("tri_time", want.tri_time, m_tdata[48:18]);
                check_field("changed",  want.changed,  m_tdata[49]);
                check_field("emptied",  want.emptied,  m_tdata[50]);
                check_field("rejected", want.rejected, m_tdata[51]);
                check_field("pad",      0,             m_tdata[55:52]);
                check_field("last",     want.last,     m_tlast);
            end
        end
    end

    // receiver with random stalls and long hold-offs
    always @(negedge aclk) begin
        if (hold_seen != hold_seq) begin
            hold_seen <= hold_seq;
            hold_left <= hold_len;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic drive_word(logic func, logic [5:0] va, logic [5:0] vb, logic [5:0] vc,
                              logic [30:0] st, logic [30:0] nt, logic [5:0] vcount);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {2'b00, vcount, nt, st, vc, vb, va};
        do @(posedge aclk); while (!s_tready);
        predict_results(func, va, vb, vc, st, nt, vcount);
    endtask

    task automatic append_triangle(logic [5:0] va, logic [5:0] vb, logic [5:0] vc,
                                   logic [30:0] st);
        drive_word(FUNC_APPEND, va, vb, vc, st, 31'($urandom), 6'($urandom));
    endtask

    task automatic sweep_table(logic [30:0] nt, logic [5:0] vcount);
        drive_word(FUNC_SWEEP, 6'($urandom), 6'($urandom), 6'($urandom),
                   31'($urandom), nt, vcount);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (awaited_words.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_stay(logic [30:0] value);
        drain_results();
        @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= STAY_ADDR;
        pwdata  <= {1'b0, value};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        stay_ms = value;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic random_append();
        logic [30:0] st;
        if ($urandom_range(0, 15) == 0) begin
            st = 31'($urandom);
        end else begin
            st = clock_ms - 31'($urandom_range(0, 150));
        end
        append_triangle(6'($urandom_range(0, 39)), 6'($urandom_range(0, 39)),
                        6'($urandom_range(0, 39)), st);
    endtask

    task automatic random_sweep();
        int          r;
        logic [5:0]  vcount;
        r = $urandom_range(0, 19);
        if (r == 0) begin
            vcount = 6'($urandom_range(41, 63));
        end else if (r < 12) begin
            vcount = 6'(NVERT);
        end else begin
            vcount = 6'($urandom_range(0, 40));
        end
        clock_ms = clock_ms + 31'($urandom_range(0, 80));
        if ($urandom_range(0, 9) == 0) begin
            sweep_table(31'($urandom), vcount);
        end else begin
            sweep_table(clock_ms, vcount);
        end
    endtask

    task automatic test_empty_sweep();
        sweep_table('0, '0);
    endtask

    task automatic test_append_extremes();
        write_stay(TIME_MAX);
        append_triangle(6'd0, 6'd0, 6'd0, '0);
        append_triangle(6'd39, 6'd39, 6'd39, TIME_MAX);
        append_triangle(6'd8, 6'd16, 6'd39, 31'h2AAA_AAAA);
        append_triangle(6'd7, 6'd23, 6'd32, 31'h5555_5555);
        // expiry limit below zero keeps everything
        sweep_table(31'd5, 6'd40);
        sweep_table(TIME_MAX, 6'd63);
        write_stay('0);
        // zero stay time drops triangles not newer than the sweep time
        sweep_table(31'h2AAA_AAAA, 6'd20);
        sweep_table(TIME_MAX, 6'd63);
    endtask

    task automatic test_full_table();
        write_stay(31'd100);
        for (int i = 0; i <= NTRI; i++) begin
            append_triangle(6'(2 * (i % NTRI)), 6'(2 * (i % NTRI) + 1), 6'((i * 7) % NVERT),
                            clock_ms);
        end
        sweep_table(clock_ms, 6'(NVERT));
    endtask

    task automatic random_phase(int send_pct, int stall, logic [30:0] stay, int count);
        int sent;
        write_stay(stay);
        send_idle_pct = send_pct;
        stall_pct     = stall;
        sent = 0;
        while (sent < count) begin
            repeat ($urandom_range(1, 8)) begin
                random_append();
                sent++;
            end
            random_sweep();
            sent++;
        end
    endtask

    task automatic test_random_phases();
        random_phase(0, 0, 31'd60, 55);
        random_phase(65, 0, 31'd150, 55);
        random_phase(0, 65, 31'd30, 55);
        random_phase(22, 22, 31'd90, 55);
    endtask

    task automatic test_backpressure();
        write_stay(31'd5000);
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_len      = 400;
        hold_seq      = hold_seq + 1;
        repeat (10) random_append();
        random_sweep();
        random_append();
        // sender waits for every word before going on
        drain_results();
        random_sweep();
    endtask

    initial begin
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        test_empty_sweep();
        test_append_extremes();
        test_full_table();
        test_random_phases();
        test_backpressure();
        drain_results();
        repeat (200) @(posedge aclk);
        if (fail_count == 0 && awaited_words.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/dtec_pkg.sv
hdl/dtec_ram.sv
hdl/decal_triangle_expiry_compactor.sv
tb/decal_triangle_expiry_compactor_tb.sv
